@@ hw/rtl/mlg_pkg.sv @@
// ----------------------------------------------------------------------------
// mlg_pkg
// Shared types, codes and helpers for the multiline log grouper: result
// kinds, register indexes and the layout of one result beat.
// ----------------------------------------------------------------------------
package mlg_pkg;

   // Width of a line index
   localparam int LINE_ID_BITS = 16;

   // Configuration port
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HAS_START      = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HAS_CONTINUE   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HAS_END        = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMATCHED_MODE = 2'd3;

   // Result kinds
   localparam int KIND_BITS = 3;
   localparam logic [KIND_BITS-1:0] KIND_JOIN   = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_COMMIT = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_SINGLE = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_UKEEP  = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_UDROP  = 3'd4;
   localparam logic [KIND_BITS-1:0] KIND_PASS   = 3'd5;

   // Most result beats one line can cause: two from the line, one flush
   localparam int MAX_RES = 3;
   localparam int CNT_BITS = 2;

   typedef logic [LINE_ID_BITS-1:0] line_id_type;

   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      line_id_type          first_id;
      line_id_type          line_id_out;
      logic                 last;
   } res_type;

   // Build one result beat, last cleared
   function automatic res_type make_res(logic [KIND_BITS-1:0] kind,
                                        line_id_type first_id,
                                        line_id_type line_id_out);
      res_type r;
      r.kind        = kind;
      r.first_id    = first_id;
      r.line_id_out = line_id_out;
      r.last        = 1'b0;
      return r;
   endfunction

endpackage

@@ hw/rtl/multiline_log_grouper.sv @@
// ----------------------------------------------------------------------------
// multiline_log_grouper
// Groups log lines into multiline records and reports the grouping
// decisions as result beats, from start/continue/end pattern hit bits.
// ----------------------------------------------------------------------------
// A line's decisions are all worked out in the cycle it is accepted and
// written to a three-entry result buffer, which drains one beat per
// cycle on the rsp channel while rsp_ready is high. A line causing at
// most one result (or none, such as an empty line) is taken every cycle
// while the consumer keeps up. A line with more than one result holds
// the rsp port until all are sent; the next line is taken in the cycle
// its last beat leaves. Configuration writes are taken at any time
// (csr_ready is always high) but must only be issued while the block is idle.
module multiline_log_grouper (
   input  logic                              clock,
   input  logic                              reset,
   // configuration
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mlg_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic                              csr_data,
   // line input
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [mlg_pkg::LINE_ID_BITS-1:0]  req_line_id,
   input  logic                              req_start_hit,
   input  logic                              req_continue_hit,
   input  logic                              req_end_hit,
   input  logic                              req_is_empty,
   input  logic                              req_is_bad,
   input  logic                              req_batch_end,
   // decisions out
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [mlg_pkg::KIND_BITS-1:0]     rsp_kind,
   output logic [mlg_pkg::LINE_ID_BITS-1:0]  rsp_first_id,
   output logic [mlg_pkg::LINE_ID_BITS-1:0]  rsp_line_id_out,
   output logic                              rsp_last
);

   // Configuration registers
   logic has_start_ff, has_continue_ff, has_end_ff, unmatched_mode_ff;

   // Grouping state
   logic                  partial_ff, partial_in;
   logic                  group_open_ff, group_open_in;
   mlg_pkg::line_id_type  group_first_ff, group_first_in;
   logic                  passing_ff, passing_in;
   logic                  fresh_ff, fresh_in;

   // Result buffer
   mlg_pkg::res_type             res_ff [mlg_pkg::MAX_RES];
   mlg_pkg::res_type             res_in [mlg_pkg::MAX_RES];
   logic [mlg_pkg::CNT_BITS-1:0] cnt_ff;
   logic [mlg_pkg::CNT_BITS-1:0] n_in;

   logic                 req_take, rsp_take;
   logic                 s_hit, c_hit, e_hit, entry;
   logic [mlg_pkg::KIND_BITS-1:0] unm_kind;
   mlg_pkg::line_id_type id;

   // Handshakes
   assign csr_ready = 1'b1;
   assign rsp_valid = (cnt_ff != '0);
   assign rsp_take  = rsp_valid && rsp_ready;
   assign req_ready = (cnt_ff == '0) || ((cnt_ff == 2'd1) && rsp_ready);
   assign req_take  = req_valid && req_ready;

   assign rsp_kind        = res_ff[0].kind;
   assign rsp_first_id    = res_ff[0].first_id;
   assign rsp_line_id_out = res_ff[0].line_id_out;
   assign rsp_last        = res_ff[0].last;

   // Mask hit bits with the configured patterns
   assign id       = req_line_id;
   assign s_hit    = req_start_hit && has_start_ff;
   assign c_hit    = req_continue_hit && has_continue_ff;
   assign e_hit    = req_end_hit && has_end_ff;
   assign entry    = has_start_ff ? s_hit : c_hit;
   assign unm_kind = unmatched_mode_ff ? mlg_pkg::KIND_UDROP : mlg_pkg::KIND_UKEEP;

   // Work out all decisions and the next state for the offered line
   always_comb begin
      partial_in     = partial_ff;
      group_open_in  = group_open_ff;
      group_first_in = group_first_ff;
      passing_in     = passing_ff;
      fresh_in       = fresh_ff;
      n_in           = '0;
      for (int i = 0; i < mlg_pkg::MAX_RES; i++) begin
         res_in[i] = mlg_pkg::make_res(mlg_pkg::KIND_JOIN, '0, '0);
      end

      // batch start: reload from configuration
      if (fresh_ff) begin
         partial_in    = !has_start_ff && !has_continue_ff && has_end_ff;
         group_open_in = 1'b0;
         passing_in    = 1'b0;
         fresh_in      = 1'b0;
      end

      if (passing_in) begin
         // rest of batch passes without results
      end else if (req_is_bad) begin
         res_in[n_in] = mlg_pkg::make_res(mlg_pkg::KIND_PASS,
                                          group_open_in ? group_first_in : id, id);
         n_in          = n_in + 2'd1;
         passing_in    = 1'b1;
         group_open_in = 1'b0;
         partial_in    = 1'b0;
      end else if (!req_is_empty) begin
         if (!partial_in) begin
            // not grouping
            if (entry) begin
               group_open_in  = 1'b1;
               group_first_in = id;
               partial_in     = 1'b1;
               res_in[n_in]   = mlg_pkg::make_res(mlg_pkg::KIND_JOIN, id, id);
            end else if (has_end_ff && !has_start_ff && has_continue_ff && e_hit) begin
               res_in[n_in] = mlg_pkg::make_res(mlg_pkg::KIND_SINGLE, id, id);
            end else begin
               res_in[n_in] = mlg_pkg::make_res(unm_kind, id, id);
            end
            n_in = n_in + 2'd1;
         end else if (c_hit) begin
            // continue line joins
            if (!group_open_in) begin
               group_open_in  = 1'b1;
               group_first_in = id;
            end
            res_in[n_in] = mlg_pkg::make_res(mlg_pkg::KIND_JOIN, group_first_in, id);
            n_in         = n_in + 2'd1;
         end else if (has_end_ff) begin
            if (!group_open_in) begin
               group_open_in  = 1'b1;
               group_first_in = id;
            end
            if (has_continue_ff) begin
               res_in[n_in] = mlg_pkg::make_res(e_hit ? mlg_pkg::KIND_COMMIT : unm_kind,
                                                group_first_in, id);
               group_open_in = 1'b0;
               partial_in    = 1'b0;
            end else if (e_hit) begin
               res_in[n_in] = mlg_pkg::make_res(mlg_pkg::KIND_COMMIT, group_first_in, id);
               group_open_in = 1'b0;
               if (has_start_ff) begin
                  partial_in = 1'b0;
               end
            end else begin
               res_in[n_in] = mlg_pkg::make_res(mlg_pkg::KIND_JOIN, group_first_in, id);
            end
            n_in = n_in + 2'd1;
         end else if (!has_continue_ff && !s_hit) begin
            // start only, no start hit: join
            if (!group_open_in) begin
               group_open_in  = 1'b1;
               group_first_in = id;
            end
            res_in[n_in] = mlg_pkg::make_res(mlg_pkg::KIND_JOIN, group_first_in, id);
            n_in         = n_in + 2'd1;
         end else begin
            // close any open group on this line
            if (group_open_in) begin
               res_in[n_in] = mlg_pkg::make_res(mlg_pkg::KIND_COMMIT, group_first_in, id);
               n_in         = n_in + 2'd1;
            end
            group_open_in = 1'b0;
            if (has_continue_ff && !s_hit) begin
               partial_in   = 1'b0;
               res_in[n_in] = mlg_pkg::make_res(unm_kind, id, id);
            end else begin
               group_open_in  = 1'b1;
               group_first_in = id;
               partial_in     = 1'b1;
               res_in[n_in]   = mlg_pkg::make_res(mlg_pkg::KIND_JOIN, id, id);
            end
            n_in = n_in + 2'd1;
         end
      end

      // batch end: flush a pending group
      if (req_batch_end) begin
         if (!passing_in && partial_in && group_open_in) begin
            res_in[n_in] = mlg_pkg::make_res(has_end_ff ? unm_kind : mlg_pkg::KIND_COMMIT,
                                             group_first_in, id);
            n_in         = n_in + 2'd1;
         end
         group_open_in = 1'b0;
         partial_in    = 1'b0;
         passing_in    = 1'b0;
         fresh_in      = 1'b1;
      end

      // mark the final beat of this line
      if (n_in != '0) begin
         res_in[n_in - 2'd1].last = 1'b1;
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         has_start_ff      <= 1'b1;
         has_continue_ff   <= 1'b0;
         has_end_ff        <= 1'b0;
         unmatched_mode_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            mlg_pkg::CSR_HAS_START:      has_start_ff      <= csr_data;
            mlg_pkg::CSR_HAS_CONTINUE:   has_continue_ff   <= csr_data;
            mlg_pkg::CSR_HAS_END:        has_end_ff        <= csr_data;
            mlg_pkg::CSR_UNMATCHED_MODE: unmatched_mode_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Advance grouping state on each accepted line
   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff    <= 1'b0;
         group_open_ff <= 1'b0;
         passing_ff    <= 1'b0;
         fresh_ff      <= 1'b1;
      end else if (req_take) begin
         partial_ff    <= partial_in;
         group_open_ff <= group_open_in;
         passing_ff    <= passing_in;
         fresh_ff      <= fresh_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         group_first_ff <= group_first_in;
      end
   end

   // Result buffer count: load on accept, drop one per beat sent
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (req_take) begin
         cnt_ff <= n_in;
      end else if (rsp_take) begin
         cnt_ff <= cnt_ff - 2'd1;
      end
   end

   // Result buffer payload: load on accept, shift down per beat sent
   always_ff @(posedge clock) begin
      if (req_take) begin
         for (int i = 0; i < mlg_pkg::MAX_RES; i++) begin
            res_ff[i] <= res_in[i];
         end
      end else if (rsp_take) begin
         for (int i = 0; i < mlg_pkg::MAX_RES - 1; i++) begin
            res_ff[i] <= res_ff[i+1];
         end
      end
   end

   // Checks
   a_not_last_more: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> cnt_ff > 2'd1)
      else $error("result beat without last has no successor in buffer");

   a_single_is_last: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd1 |-> res_ff[0].last)
      else $error("sole buffered beat lacks last");

   a_batch_end_fresh: assert property (@(posedge clock) disable iff (reset)
      req_take && req_batch_end |=> fresh_ff && !group_open_ff && !passing_ff)
      else $error("batch end did not return to batch start");

   a_passing_closed: assert property (@(posedge clock) disable iff (reset)
      passing_ff |-> !group_open_ff && !partial_ff)
      else $error("group open while passing rest of batch");

endmodule
